[rtl/tcd_pkg.sv]
// Package for the tilt crash detector: shared widths, constants and the
// arctangent table. No dependencies.
package tcd_pkg;

    localparam int SampleW   = 16;
    localparam int SumW      = 22;
    localparam int AngleW    = 15;
    localparam int DeadW     = 14;
    localparam int LimitW    = 15;
    localparam int CfgW      = 15;
    localparam int AccW      = 26;
    localparam int CordW     = 36;
    localparam int TableLen  = 24;
    localparam int AngleMax  = 11520;
    localparam int Deg180    = 180 * 65536;

    localparam logic CfgDeadZone   = 1'b0;
    localparam logic CfgCrashLimit = 1'b1;

    localparam logic CmdSample = 1'b0;
    localparam logic CmdRearm  = 1'b1;

    // Datapath commands issued by the controller.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_ACCUM,
        OP_CLEAR,
        OP_MEANS,
        OP_SQ_Y,
        OP_SQ_Z,
        OP_SQRT_INIT,
        OP_SQRT_STEP,
        OP_CORD_ROLL,
        OP_CORD_PITCH,
        OP_CORD_STEP,
        OP_FINISH_ROLL,
        OP_FINISH_PITCH,
        OP_CRASH
    } dp_op_t;

    typedef struct packed {
        dp_op_t     op;
        logic [4:0] step;
    } dp_cmd_t;

    typedef struct packed {
        logic batch_done;
    } dp_status_t;

    function automatic logic signed [AccW-1:0] atan_entry(input logic [4:0] i);
        logic signed [AccW-1:0] v;
        v = '0;
        case (i)
            5'd0:  v = 26'sd2949120;
            5'd1:  v = 26'sd1740967;
            5'd2:  v = 26'sd919879;
            5'd3:  v = 26'sd466945;
            5'd4:  v = 26'sd234379;
            5'd5:  v = 26'sd117304;
            5'd6:  v = 26'sd58666;
            5'd7:  v = 26'sd29335;
            5'd8:  v = 26'sd14668;
            5'd9:  v = 26'sd7334;
            5'd10: v = 26'sd3667;
            5'd11: v = 26'sd1833;
            5'd12: v = 26'sd917;
            5'd13: v = 26'sd458;
            5'd14: v = 26'sd229;
            5'd15: v = 26'sd115;
            5'd16: v = 26'sd57;
            5'd17: v = 26'sd29;
            5'd18: v = 26'sd14;
            5'd19: v = 26'sd7;
            5'd20: v = 26'sd4;
            5'd21: v = 26'sd2;
            5'd22: v = 26'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[rtl/tcd_if.sv]
// Valid/ready channel interfaces for the tilt crash detector.
// Depends on tcd_pkg for the field widths.
interface tcd_in_if import tcd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic signed [SampleW-1:0] accel_x;
    logic signed [SampleW-1:0] accel_y;
    logic signed [SampleW-1:0] accel_z;
    modport source (output valid, cmd, accel_x, accel_y, accel_z, input ready);
    modport sink (input valid, cmd, accel_x, accel_y, accel_z, output ready);
endinterface

interface tcd_out_if import tcd_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      crash;
    logic signed [AngleW-1:0]  pitch_angle;
    logic signed [AngleW-1:0]  roll_angle;
    logic signed [SampleW-1:0] mean_x;
    logic signed [SampleW-1:0] mean_y;
    logic signed [SampleW-1:0] mean_z;
    modport source (output valid, crash, pitch_angle, roll_angle, mean_x, mean_y,
                    mean_z, input ready);
    modport sink (input valid, crash, pitch_angle, roll_angle, mean_x, mean_y,
                  mean_z, output ready);
endinterface

[rtl/tcd_datapath.sv]
// Datapath of the tilt crash detector: accumulators, means, square root,
// shared CORDIC unit and crash latch. Depends on tcd_pkg.
module tcd_datapath import tcd_pkg::*; #(
    parameter int SAMPLE_COUNT = 8
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  dp_cmd_t                   cmd,
    input  logic signed [SampleW-1:0] in_x,
    input  logic signed [SampleW-1:0] in_y,
    input  logic signed [SampleW-1:0] in_z,
    input  logic [DeadW-1:0]          dead_zone,
    input  logic [LimitW-1:0]         crash_limit,
    output dp_status_t                status,
    output logic                      crash,
    output logic signed [AngleW-1:0]  pitch_angle,
    output logic signed [AngleW-1:0]  roll_angle,
    output logic signed [SampleW-1:0] mean_x,
    output logic signed [SampleW-1:0] mean_y,
    output logic signed [SampleW-1:0] mean_z
);

    localparam int CntW = $clog2(SAMPLE_COUNT + 1);
    localparam int SqW  = 32;
    localparam int RadW = 34;

    // Reciprocal of the batch size, exact for every sum magnitude up to 2^SumW.
    localparam int RecipSh = SumW + $clog2(SAMPLE_COUNT);
    localparam int RecipW  = SumW + 2;
    localparam logic [RecipW-1:0] RecipM =
        RecipW'(((64'd1 << RecipSh) + 64'(SAMPLE_COUNT) - 64'd1) / 64'(SAMPLE_COUNT));

    logic signed [SumW-1:0] sum_x_reg, sum_y_reg, sum_z_reg;
    logic [CntW-1:0]        cnt_reg;
    logic                   latch_reg;
    logic [RadW-1:0]        rad_reg;
    logic [RadW-1:0]        rem_reg;
    logic [17:0]            root_reg;
    logic signed [CordW-1:0] cx_reg, cy_reg;
    logic signed [AccW-1:0]  ang_reg;
    logic                    zero_reg;

    logic [CntW-1:0] cnt_next;
    assign cnt_next = cnt_reg + CntW'(1);
    assign status.batch_done = (cnt_next == CntW'(SAMPLE_COUNT));

    // Truncating division toward zero by the batch size: the magnitude is
    // scaled by the reciprocal and the sign is put back afterwards.
    function automatic logic signed [SampleW-1:0] mean_of(input logic signed [SumW-1:0] s);
        logic [SumW-1:0]        mag_s;
        logic [SumW+RecipW-1:0] prod;
        logic [SumW-1:0]        quo;
        mag_s = s[SumW-1] ? SumW'(-s) : SumW'(s);
        prod  = (SumW+RecipW)'(mag_s) * (SumW+RecipW)'(RecipM);
        quo   = SumW'(prod >> RecipSh);
        return s[SumW-1] ? SampleW'(-quo) : SampleW'(quo);
    endfunction

    // Restoring square root, one result bit per step.
    logic [RadW-1:0] trial;
    logic [RadW-1:0] rem_shift;
    logic [4:0]      sq_pos;
    assign sq_pos    = 5'd16 - cmd.step;
    assign rem_shift = {rem_reg[RadW-3:0], rad_reg[2*sq_pos +: 2]};
    assign trial     = {14'd0, root_reg, 2'b01};

    // CORDIC micro-rotation.
    logic signed [CordW-1:0] sh_x, sh_y;
    assign sh_x = cx_reg >>> cmd.step;
    assign sh_y = cy_reg >>> cmd.step;

    // Angle rounding, saturation and dead zone.
    logic [AccW-1:0]  mag;
    logic [AccW-1:0]  rnd;
    logic [AngleW-1:0] q;
    logic signed [AngleW-1:0] ang_q;
    always_comb
    begin
        mag = ang_reg[AccW-1] ? AccW'(-ang_reg) : AccW'(ang_reg);
        rnd = (mag + AccW'(512)) >> 10;
        q   = (rnd > AccW'(AngleMax)) ? AngleW'(AngleMax) : rnd[AngleW-1:0];
        if (zero_reg || (q <= AngleW'(dead_zone)))
            ang_q = '0;
        else
            ang_q = ang_reg[AccW-1] ? -$signed(q) : $signed(q);
    end

    logic [AngleW:0] total;
    assign total = {1'b0, pitch_angle[AngleW-1] ? AngleW'(-pitch_angle) : pitch_angle}
                 + {1'b0, roll_angle[AngleW-1] ? AngleW'(-roll_angle) : roll_angle};

    logic signed [CordW-1:0] num_w, den_w;
    always_comb
    begin
        num_w = '0;
        den_w = '0;
        if (cmd.op == OP_CORD_ROLL)
        begin
            num_w = CordW'(-$signed({{2{mean_y[SampleW-1]}}, mean_y})) <<< 16;
            den_w = CordW'(mean_z) <<< 16;
        end
        else
        begin
            num_w = CordW'(mean_x) <<< 16;
            den_w = CordW'($signed({1'b0, root_reg})) <<< 16;
        end
    end

    logic signed [SqW-1:0] ext_y, ext_z;
    logic [SqW-1:0] sq;
    assign ext_y = SqW'(mean_y);
    assign ext_z = SqW'(mean_z);
    assign sq = (cmd.op == OP_SQ_Y) ? SqW'(ext_y * ext_y) : SqW'(ext_z * ext_z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg <= '0;
            sum_y_reg <= '0;
            sum_z_reg <= '0;
            cnt_reg   <= '0;
            latch_reg <= 1'b0;
        end
        else
        begin
            case (cmd.op)
                OP_CLEAR:
                begin
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    sum_z_reg <= '0;
                    cnt_reg   <= '0;
                    latch_reg <= 1'b0;
                end
                OP_ACCUM:
                begin
                    sum_x_reg <= sum_x_reg + SumW'(in_x);
                    sum_y_reg <= sum_y_reg + SumW'(in_y);
                    sum_z_reg <= sum_z_reg + SumW'(in_z);
                    cnt_reg   <= cnt_next;
                end
                OP_MEANS:
                begin
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    sum_z_reg <= '0;
                    cnt_reg   <= '0;
                end
                OP_CRASH:
                    if (total >= (AngleW+1)'(crash_limit))
                        latch_reg <= 1'b1;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (cmd.op)
            OP_MEANS:
            begin
                mean_x <= mean_of(sum_x_reg);
                mean_y <= mean_of(sum_y_reg);
                mean_z <= mean_of(sum_z_reg);
            end
            OP_SQ_Y: rad_reg <= RadW'(sq);
            OP_SQ_Z: rad_reg <= rad_reg + RadW'(sq);
            OP_SQRT_INIT:
            begin
                rem_reg  <= '0;
                root_reg <= '0;
            end
            OP_SQRT_STEP:
                if (rem_shift >= trial)
                begin
                    rem_reg  <= rem_shift - trial;
                    root_reg <= {root_reg[16:0], 1'b1};
                end
                else
                begin
                    rem_reg  <= rem_shift;
                    root_reg <= {root_reg[16:0], 1'b0};
                end
            OP_CORD_ROLL, OP_CORD_PITCH:
            begin
                zero_reg <= (num_w == '0) && (den_w == '0);
                if (den_w < 0)
                begin
                    ang_reg <= (num_w >= 0) ? AccW'(Deg180) : AccW'(-Deg180);
                    cx_reg  <= -den_w;
                    cy_reg  <= -num_w;
                end
                else
                begin
                    ang_reg <= '0;
                    cx_reg  <= den_w;
                    cy_reg  <= num_w;
                end
            end
            OP_CORD_STEP:
                if (cy_reg > 0)
                begin
                    cx_reg  <= cx_reg + sh_y;
                    cy_reg  <= cy_reg - sh_x;
                    ang_reg <= ang_reg + atan_entry(cmd.step);
                end
                else
                begin
                    cx_reg  <= cx_reg - sh_y;
                    cy_reg  <= cy_reg + sh_x;
                    ang_reg <= ang_reg - atan_entry(cmd.step);
                end
            OP_FINISH_ROLL:  roll_angle  <= ang_q;
            OP_FINISH_PITCH: pitch_angle <= ang_q;
            OP_CRASH: crash <= latch_reg || (total >= (AngleW+1)'(crash_limit));
            default: ;
        endcase
    end

endmodule

[rtl/tcd_ctrl.sv]
// Controller of the tilt crash detector: sequences accumulation, means,
// square root, the two CORDIC passes and the crash check. Depends on tcd_pkg.
module tcd_ctrl import tcd_pkg::*; #(
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic       in_cmd,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_cmd_t    cmd
);

    localparam int Iters = (ANGLE_ITERATIONS > TableLen) ? TableLen : ANGLE_ITERATIONS;

    typedef enum logic [3:0] {
        S_IDLE, S_MEANS, S_SQY, S_SQZ, S_SQI, S_SQRT, S_RINIT, S_RSTEP, S_RFIN,
        S_PINIT, S_PSTEP, S_PFIN, S_CRASH, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       busy;

    // The result register holds until taken; a new batch may not start before.
    assign in_ready = (state_reg == S_IDLE) && !out_valid;

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd.op     = OP_NONE;
        cmd.step   = step_reg;
        busy       = 1'b0;
        case (state_reg)
            S_IDLE:
                if (in_valid && in_ready)
                begin
                    if (in_cmd == CmdRearm)
                        cmd.op = OP_CLEAR;
                    else
                    begin
                        cmd.op = OP_ACCUM;
                        if (status.batch_done)
                            state_next = S_MEANS;
                    end
                end
            S_MEANS: begin cmd.op = OP_MEANS; state_next = S_SQY; end
            S_SQY:   begin cmd.op = OP_SQ_Y;  state_next = S_SQZ; end
            S_SQZ:   begin cmd.op = OP_SQ_Z;  state_next = S_SQI; end
            S_SQI:
            begin
                cmd.op = OP_SQRT_INIT;
                step_next = '0;
                state_next = S_SQRT;
            end
            S_SQRT:
            begin
                cmd.op = OP_SQRT_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'd16)
                    state_next = S_RINIT;
            end
            S_RINIT:
            begin
                cmd.op = OP_CORD_ROLL;
                step_next = '0;
                state_next = S_RSTEP;
            end
            S_RSTEP:
            begin
                cmd.op = OP_CORD_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(Iters - 1))
                    state_next = S_RFIN;
            end
            S_RFIN:  begin cmd.op = OP_FINISH_ROLL; state_next = S_PINIT; end
            S_PINIT:
            begin
                cmd.op = OP_CORD_PITCH;
                step_next = '0;
                state_next = S_PSTEP;
            end
            S_PSTEP:
            begin
                cmd.op = OP_CORD_STEP;
                step_next = step_reg + 5'd1;
                if (step_reg == 5'(Iters - 1))
                    state_next = S_PFIN;
            end
            S_PFIN:  begin cmd.op = OP_FINISH_PITCH; state_next = S_CRASH; end
            S_CRASH: begin cmd.op = OP_CRASH; state_next = S_OUT; end
            S_OUT:   begin busy = 1'b1; state_next = S_IDLE; end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            out_valid <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (busy)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
        end
    end

endmodule

[rtl/tilt_crash_detector.sv]
// Top level of the tilt crash detector: joins controller and datapath.
// Depends on tcd_pkg, tcd_if, tcd_ctrl and tcd_datapath.
//
// Usage: words arrive on the input channel (valid/ready). A word with cmd
// high rearms: it clears the crash latch and the current batch and gives no
// result. A sample word adds to the per-axis sums; the word that completes
// a batch of SAMPLE_COUNT samples starts the angle computation, and one
// result word later appears on the output channel with the means, roll,
// pitch and crash flag.
// A sample word that does not complete a batch only adds to the sums. The
// completing word runs the means, the 17-step square root, the two passes
// through the shared CORDIC unit and the crash check, and its result then
// waits on the output channel until it is taken.
// While a result waits in the output register no input word is accepted.
// Reset clears sums, count and latch and loads the register defaults; the
// configuration port writes dead_zone (index 0) and crash_limit (index 1).
module tilt_crash_detector import tcd_pkg::*; #(
    parameter int SAMPLE_COUNT     = 8,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    tcd_in_if.sink          in_ch,
    tcd_out_if.source       out_ch,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [CfgW-1:0] cfg_data
);

    logic [DeadW-1:0]  dead_zone_reg;
    logic [LimitW-1:0] crash_limit_reg;
    dp_cmd_t           cmd;
    dp_status_t        status;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dead_zone_reg   <= DeadW'(3840);
            crash_limit_reg <= LimitW'(9600);
        end
        else if (cfg_we)
        begin
            if (cfg_index == CfgDeadZone)
                dead_zone_reg <= cfg_data[DeadW-1:0];
            else
                crash_limit_reg <= cfg_data[LimitW-1:0];
        end
    end

    tcd_ctrl #(
        .ANGLE_ITERATIONS(ANGLE_ITERATIONS)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_ch.valid),
        .in_cmd    (in_ch.cmd),
        .in_ready  (in_ch.ready),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcd_datapath #(
        .SAMPLE_COUNT(SAMPLE_COUNT)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .in_x        (in_ch.accel_x),
        .in_y        (in_ch.accel_y),
        .in_z        (in_ch.accel_z),
        .dead_zone   (dead_zone_reg),
        .crash_limit (crash_limit_reg),
        .status      (status),
        .crash       (out_ch.crash),
        .pitch_angle (out_ch.pitch_angle),
        .roll_angle  (out_ch.roll_angle),
        .mean_x      (out_ch.mean_x),
        .mean_y      (out_ch.mean_y),
        .mean_z      (out_ch.mean_z)
    );

endmodule

[sim/tilt_crash_checker.sv]
// Checker for the tilt crash detector: watches both channels and the register
// port, predicts every result word and compares it field by field.
// Depends on tcd_pkg and the channel interfaces in tcd_if.
module tilt_crash_checker import tcd_pkg::*; #(
    parameter int SAMPLE_COUNT     = 8,
    parameter int ANGLE_ITERATIONS = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    tcd_in_if               in_ch,
    tcd_out_if              out_ch,
    input  logic            cfg_we,
    input  logic            cfg_index,
    input  logic [CfgW-1:0] cfg_data,
    output int              fail_count,
    output int              pending
);

    typedef struct packed {
        logic                      crash;
        logic signed [AngleW-1:0]  pitch;
        logic signed [AngleW-1:0]  roll;
        logic signed [SampleW-1:0] mx;
        logic signed [SampleW-1:0] my;
        logic signed [SampleW-1:0] mz;
    } tilt_word_t;

    tilt_word_t   tilt_q[$];
    logic [DeadW-1:0]  dead_zone;
    logic [LimitW-1:0] crash_limit;
    longint       acc_x, acc_y, acc_z;
    int           batch_n;
    logic         latched;

    // Angle table in 2^-16 degree.
    function automatic longint atan_step(int i);
        longint tab[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666,
                            29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
                            57, 29, 14, 7, 4, 2, 1, 0};
        return tab[i];
    endfunction

    function automatic longint floor_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return longint'(res);
    endfunction

    // Vectoring arctangent in 1/64 degree, saturated to the angle range.
    function automatic longint tilt_atan2(longint num, longint den);
        longint x, y, t, ang, mag, q;
        int n;
        ang = 0;
        if (num == 0 && den == 0)
            return 0;
        x = den * 65536;
        y = num * 65536;
        if (x < 0)
        begin
            ang = (y >= 0) ? 180 * 65536 : -180 * 65536;
            x = -x;
            y = -y;
        end
        n = (ANGLE_ITERATIONS > 24) ? 24 : ANGLE_ITERATIONS;
        for (int i = 0; i < n; i++)
        begin
            if (y > 0)
            begin
                t = x + (y >>> i);
                y = y - (x >>> i);
                ang += atan_step(i);
            end
            else
            begin
                t = x - (y >>> i);
                y = y + (x >>> i);
                ang -= atan_step(i);
            end
            x = t;
        end
        mag = (ang < 0) ? -ang : ang;
        q = (mag + 512) >> 10;
        if (q > AngleMax)
            q = AngleMax;
        return (ang < 0) ? -q : q;
    endfunction

    function automatic longint zero_small(longint a, longint bound);
        longint m;
        m = (a < 0) ? -a : a;
        return (m <= bound) ? 0 : a;
    endfunction

    task automatic take_sample(logic signed [SampleW-1:0] sx, logic signed [SampleW-1:0] sy,
                               logic signed [SampleW-1:0] sz);
        longint m_x, m_y, m_z, roll, pitch, r, total;
        tilt_word_t w;
        acc_x += sx;
        acc_y += sy;
        acc_z += sz;
        batch_n++;
        if (batch_n < SAMPLE_COUNT)
            return;
        m_x = acc_x / SAMPLE_COUNT;
        m_y = acc_y / SAMPLE_COUNT;
        m_z = acc_z / SAMPLE_COUNT;
        acc_x = 0;
        acc_y = 0;
        acc_z = 0;
        batch_n = 0;
        roll = zero_small(tilt_atan2(-m_y, m_z), dead_zone);
        r = floor_sqrt(m_y * m_y + m_z * m_z);
        pitch = zero_small(tilt_atan2(m_x, r), dead_zone);
        total = ((pitch < 0) ? -pitch : pitch) + ((roll < 0) ? -roll : roll);
        if (!latched && total >= crash_limit)
            latched = 1'b1;
        w.crash = latched;
        w.pitch = pitch[AngleW-1:0];
        w.roll  = roll[AngleW-1:0];
        w.mx    = m_x[SampleW-1:0];
        w.my    = m_y[SampleW-1:0];
        w.mz    = m_z[SampleW-1:0];
        tilt_q.push_back(w);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tilt_q.delete();
            dead_zone = 3840;
            crash_limit = 9600;
            acc_x = 0;
            acc_y = 0;
            acc_z = 0;
            batch_n = 0;
            latched = 1'b0;
            fail_count = 0;
            pending = 0;
        end
        else
        begin
            // Output first: a result word can never stem from a word taken at this edge.
            if (out_ch.valid && out_ch.ready)
            begin
                if (tilt_q.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    tilt_word_t e;
                    e = tilt_q.pop_front();
                    if (out_ch.crash !== e.crash)
                    begin
                        $error("crash: expected %0d, got %0d", e.crash, out_ch.crash);
                        fail_count++;
                    end
                    if (out_ch.pitch_angle !== e.pitch)
                    begin
                        $error("pitch_angle: expected %0d, got %0d", e.pitch,
                               out_ch.pitch_angle);
                        fail_count++;
                    end
                    if (out_ch.roll_angle !== e.roll)
                    begin
                        $error("roll_angle: expected %0d, got %0d", e.roll, out_ch.roll_angle);
                        fail_count++;
                    end
                    if (out_ch.mean_x !== e.mx)
                    begin
                        $error("mean_x: expected %0d, got %0d", e.mx, out_ch.mean_x);
                        fail_count++;
                    end
                    if (out_ch.mean_y !== e.my)
                    begin
                        $error("mean_y: expected %0d, got %0d", e.my, out_ch.mean_y);
                        fail_count++;
                    end
                    if (out_ch.mean_z !== e.mz)
                    begin
                        $error("mean_z: expected %0d, got %0d", e.mz, out_ch.mean_z);
                        fail_count++;
                    end
                end
            end
            if (cfg_we)
            begin
                if (cfg_index == CfgDeadZone)
                    dead_zone = cfg_data[DeadW-1:0];
                else
                    crash_limit = cfg_data[LimitW-1:0];
            end
            if (in_ch.valid && in_ch.ready)
            begin
                if (in_ch.cmd == CmdRearm)
                begin
                    latched = 1'b0;
                    acc_x = 0;
                    acc_y = 0;
                    acc_z = 0;
                    batch_n = 0;
                end
                else
                    take_sample(in_ch.accel_x, in_ch.accel_y, in_ch.accel_z);
            end
            pending = tilt_q.size();
        end
    end

endmodule

[sim/tilt_crash_detector_test.sv]
// Testbench top for the tilt crash detector: clock, reset, stimulus, register
// writes and the verdict. Depends on tcd_pkg, tcd_if and tilt_crash_checker.
module tilt_crash_detector_test;
    import tcd_pkg::*;

    logic            clk;
    logic            rst_n;
    logic            cfg_we;
    logic            cfg_index;
    logic [CfgW-1:0] cfg_data;
    int              fail_count;
    int              pending;
    int              send_idle_pct;
    int              stall_pct;

    tcd_in_if  in_ch();
    tcd_out_if out_ch();

    tilt_crash_detector uut (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    tilt_crash_checker u_checker (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending(pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #40_000_000;
        $display("simulation failed");
        $finish;
    end

    always @(posedge clk)
        out_ch.ready <= ($urandom_range(99) >= stall_pct);

    task automatic send_word(logic cmd, logic [SampleW-1:0] x, logic [SampleW-1:0] y,
                             logic [SampleW-1:0] z);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.cmd     <= cmd;
        in_ch.accel_x <= x;
        in_ch.accel_y <= y;
        in_ch.accel_z <= z;
        @(posedge clk);
        while (!in_ch.ready)
            @(posedge clk);
    endtask

    // Waits until no result word is owed and the block has gone quiet.
    task automatic drain();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [CfgW-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [SampleW-1:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'h7FFF;
            1: return 16'h8000;
            2: return 16'($signed($urandom_range(0, 64)) - 32);
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic send_batch(logic [SampleW-1:0] x, logic [SampleW-1:0] y,
                              logic [SampleW-1:0] z);
        repeat (8) send_word(CmdSample, x, y, z);
    endtask

    initial
    begin
        int gx, gy, gz;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = CfgDeadZone;
        cfg_data = '0;
        in_ch.valid = 1'b0;
        in_ch.cmd = CmdSample;
        in_ch.accel_x = '0;
        in_ch.accel_y = '0;
        in_ch.accel_z = '0;
        out_ch.ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: both operands zero, extremes, a negative z axis with zero y,
        // and a rearm in the middle of a batch and after a crash.
        send_batch(16'h0000, 16'h0000, 16'h0000);
        send_batch(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_batch(16'h8000, 16'h8000, 16'h8000);
        send_word(CmdRearm, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_batch(16'h0000, 16'h0000, 16'h8000);
        send_word(CmdSample, 16'h1234, 16'h8000, 16'h0001);
        send_word(CmdRearm, 16'h0000, 16'h0000, 16'h0000);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  stall_pct = 0;  end
                1: begin send_idle_pct = 53; stall_pct = 0;  end
                2: begin send_idle_pct = 0;  stall_pct = 53; end
                default: begin send_idle_pct = 31; stall_pct = 31; end
            endcase
            case (ph)
                0: begin write_reg(CfgDeadZone, 15'd0); write_reg(CfgCrashLimit, 15'd0); end
                1:
                begin
                    write_reg(CfgDeadZone, 15'd11520);
                    write_reg(CfgCrashLimit, 15'd23040);
                end
                2: begin write_reg(CfgDeadZone, 15'h7FFF); write_reg(CfgCrashLimit, 15'h7FFF); end
                3:
                begin
                    write_reg(CfgDeadZone, 15'd3840);
                    write_reg(CfgCrashLimit, 15'd9600);
                end
                default:
                begin
                    write_reg(CfgDeadZone, 15'($urandom_range(0, 11520)));
                    write_reg(CfgCrashLimit, 15'($urandom_range(0, 23040)));
                end
            endcase
            for (int k = 0; k < 14; k++)
            begin
                // Mostly steady tilts with jitter so the means land in every quadrant.
                gx = $signed(pick_sample());
                gy = $signed(pick_sample());
                gz = $signed(pick_sample());
                for (int s = 0; s < 8; s++)
                begin
                    if ($urandom_range(99) < 4)
                        send_word(CmdRearm, 16'($urandom), 16'($urandom), 16'($urandom));
                    else if ($urandom_range(99) < 15)
                        send_word(CmdSample, pick_sample(), pick_sample(), pick_sample());
                    else
                        send_word(CmdSample, 16'(gx), 16'(gy), 16'(gz));
                end
            end
            drain();
        end

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
